@@ hw/rtl/chunked_map_header_parser_assert.svh @@
// assertion helpers for the map header parser, clocked on clk, off during reset
`ifndef CHUNKED_MAP_HEADER_PARSER_ASSERT_SVH
`define CHUNKED_MAP_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define CMHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cmhp_pkg.sv @@
`default_nettype none
package cmhp_pkg;

	typedef enum logic [2:0] {
		CK_HEADER = 3'd0,
		CK_MPHD   = 3'd1,
		CK_MAIN   = 3'd2,
		CK_MWMO   = 3'd3,
		CK_OTHER  = 3'd4
	} chunk_kind_t;

	typedef enum logic [1:0] {
		KIND_TILE   = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_STATUS = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_TRUNC_BODY  = 2'd1,
		ST_PARTIAL_HDR = 2'd2,
		ST_TOO_SHORT   = 2'd3
	} status_t;

	// tags as read in file order, first byte in the top
	// any other tag (MODF included) is skipped
	localparam logic [31:0] TAG_MPHD = 32'h4D50_4844;
	localparam logic [31:0] TAG_MAIN = 32'h4D41_494E;
	localparam logic [31:0] TAG_MWMO = 32'h4D57_4D4F;

	localparam logic [31:0] GLOBAL_MASK    = 32'h0000_0001;
	localparam logic [3:0]  MIN_FILE_BYTES = 4'd8;
	localparam logic [2:0]  HDR_LAST_BYTE  = 3'd7;

	typedef struct packed {
		res_kind_t   kind;
		logic [11:0] tile_index;
		logic        tile_present;
		logic [7:0]  name_char;
		logic        name_first;
		logic [31:0] header_flags;
		logic        has_global_object;
		logic        has_grid;
		status_t     status;
		logic        last;
	} result_t;

	function automatic logic [31:0] swap_tag(input logic [31:0] t);
		return {t[7:0], t[15:8], t[23:16], t[31:24]};
	endfunction

	function automatic chunk_kind_t kind_of_tag(input logic [31:0] t, input logic swap);
		logic [31:0] v;
		v = swap ? swap_tag(t) : t;
		if (v == TAG_MPHD)
			return CK_MPHD;
		else if (v == TAG_MAIN)
			return CK_MAIN;
		else if (v == TAG_MWMO)
			return CK_MWMO;
		return CK_OTHER;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/chunked_map_header_parser.sv @@
`default_nettype none
// channel   | dir | signals                                   | request
// ----------+-----+-------------------------------------------+----------------------------
// s_axis    | in  | tvalid tready tdata[7:0] tlast            | one file byte, tlast = eof
// m_axis    | out | tvalid tready tdata[63:0] tuser[1:0] tlast| one result, tlast = last
// cfg       | in  | cfg_valid cfg_ready cfg_data[0:0]         | tag_byte_order write
//
// one file byte per cycle while the result queue has room; a byte goes input register ->
// parse logic -> result queue, and its first result is offered once it is in the queue
// a byte with two results (entry or name byte plus final status) pushes both into the queue;
// the 4-entry result queue takes a byte while two slots are free
// arst_n clears all parse state and the config register; state also clears after eof
// cfg is always ready; write it only while the parser is idle (the block does not enforce this)
module chunked_map_header_parser #(
	parameter int GRID_SIDE   = 64,
	parameter int ENTRY_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_data,      // [0] tag_byte_order
	// byte input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] file_byte
	input  wire logic        s_axis_tlast,  // end_of_file
	// result output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [11:0] tile_index, [12] tile_present, [20:13] name_char, [21] name_first,
	// [53:22] header_flags, [54] has_global_object, [55] has_grid, [57:56] status, rest 0
	output logic [63:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,  // [1:0] kind
	output logic             m_axis_tlast   // last_of_run
);

	localparam int GRID_N  = GRID_SIDE * GRID_SIDE;
	localparam int PH_W    = $clog2(ENTRY_BYTES);
	localparam int Q_DEPTH = 4;
	localparam int QP_W    = 2;

	// config register
	logic tag_order_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// parse state
	cmhp_pkg::chunk_kind_t ck_q, ck_d;
	logic [2:0]  hcnt_q, hcnt_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] size_q, size_d;
	logic [31:0] body_q, body_d;
	logic [PH_W-1:0] ph_q, ph_d;
	logic [12:0] ent_q, ent_d;
	logic        name_open_q, name_open_d;
	logic [31:0] pend_q, pend_d;
	logic [31:0] flags_q, flags_d;
	logic        global_q, global_d;
	logic        grid_q, grid_d;
	logic [3:0]  total_q, total_d;

	// result queue
	cmhp_pkg::result_t q_mem_q [Q_DEPTH];
	logic [QP_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QP_W:0]   cnt_q;

	logic fire, pop;

	// shared decode of the byte in the input register
	logic in_hdr, hdr_done, size_zero, body_end;
	logic [31:0] tag_new, size_new, size_base, body_next, pend_new;
	cmhp_pkg::chunk_kind_t tag_kind;
	logic grid_hit, name_hit, empty_body, empty_hdr;
	logic [3:0] total_new;
	logic commit_flags;

	cmhp_pkg::result_t res_a, res_b;
	logic res_a_v;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_order_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			tag_order_q <= cfg_data[0];
		end
	end

	// byte moves on when the queue has room for two results
	assign fire          = valid_s1 && (cnt_q <= (QP_W+1)'(Q_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eof_s1  <= s_axis_tlast;
		end
	end

	// header phase: tag in bytes 0..3, little-endian size in bytes 4..7
	assign in_hdr    = (ck_q == cmhp_pkg::CK_HEADER);
	assign hdr_done  = in_hdr && (hcnt_q == cmhp_pkg::HDR_LAST_BYTE);
	assign tag_new   = (hcnt_q == 3'd0) ? {24'd0, byte_s1}
		: (!hcnt_q[2] ? {tag_q[23:0], byte_s1} : tag_q);
	assign size_base = (hcnt_q == 3'd0) ? 32'd0 : size_q;
	assign size_new  = hcnt_q[2] ? (size_base | ({24'd0, byte_s1} << {hcnt_q[1:0], 3'b000}))
		: size_base;
	assign size_zero = (size_new == 32'd0);
	assign tag_kind  = cmhp_pkg::kind_of_tag(tag_new, tag_order_q);

	// body phase
	assign body_next = body_q + 32'd1;
	assign body_end  = !in_hdr && (body_next == size_q);
	assign pend_new  = ((ck_q == cmhp_pkg::CK_MPHD) && (body_q < 32'd4))
		? (pend_q | ({24'd0, byte_s1} << {body_q[1:0], 3'b000})) : pend_q;
	assign commit_flags = body_end && (ck_q == cmhp_pkg::CK_MPHD) && (size_q >= 32'd4);

	assign grid_hit   = (ck_q == cmhp_pkg::CK_MAIN) && (ph_q == '0)
		&& (ent_q < 13'(GRID_N))
		&& (({1'b0, body_q} + 33'(ENTRY_BYTES)) <= {1'b0, size_q});
	assign name_hit   = (ck_q == cmhp_pkg::CK_MWMO) && name_open_q && (byte_s1 != 8'd0);
	assign empty_body = (ck_q == cmhp_pkg::CK_MWMO) && name_open_q && (byte_s1 == 8'd0)
		&& (body_q == 32'd0);
	// name chunk with an empty body restarts the name as empty
	assign empty_hdr  = hdr_done && size_zero && (tag_kind == cmhp_pkg::CK_MWMO);

	assign total_new = (total_q == 4'hF) ? total_q : total_q + 4'd1;

	// next state
	always_comb begin
		ck_d        = ck_q;
		hcnt_d      = hcnt_q;
		tag_d       = tag_q;
		size_d      = size_q;
		body_d      = body_q;
		ph_d        = ph_q;
		ent_d       = ent_q;
		name_open_d = name_open_q;
		pend_d      = pend_q;
		flags_d     = flags_q;
		global_d    = global_q;
		grid_d      = grid_q;
		total_d     = total_new;
		if (in_hdr) begin
			tag_d  = tag_new;
			size_d = size_new;
			if (hdr_done) begin
				hcnt_d      = 3'd0;
				body_d      = 32'd0;
				ph_d        = '0;
				ent_d       = 13'd0;
				pend_d      = 32'd0;
				ck_d        = size_zero ? cmhp_pkg::CK_HEADER : tag_kind;
				name_open_d = (tag_kind == cmhp_pkg::CK_MWMO) && !size_zero;
				if (size_zero && (tag_kind == cmhp_pkg::CK_MAIN))
					grid_d = 1'b1;
			end else begin
				hcnt_d = hcnt_q + 3'd1;
			end
		end else begin
			body_d = body_next;
			ph_d   = (ph_q == PH_W'(ENTRY_BYTES - 1)) ? '0 : ph_q + PH_W'(1);
			pend_d = pend_new;
			if (grid_hit)
				ent_d = ent_q + 13'd1;
			if ((ck_q == cmhp_pkg::CK_MWMO) && (byte_s1 == 8'd0))
				name_open_d = 1'b0;
			if (commit_flags) begin
				flags_d  = pend_new;
				global_d = |(pend_new & cmhp_pkg::GLOBAL_MASK);
			end
			if (body_end) begin
				ck_d        = cmhp_pkg::CK_HEADER;
				name_open_d = 1'b0;
				if (ck_q == cmhp_pkg::CK_MAIN)
					grid_d = 1'b1;
			end
		end
		// end of file: back to reset so the next byte starts a new file
		if (eof_s1) begin
			ck_d        = cmhp_pkg::CK_HEADER;
			hcnt_d      = 3'd0;
			tag_d       = 32'd0;
			size_d      = 32'd0;
			body_d      = 32'd0;
			ph_d        = '0;
			ent_d       = 13'd0;
			name_open_d = 1'b0;
			pend_d      = 32'd0;
			flags_d     = 32'd0;
			global_d    = 1'b0;
			grid_d      = 1'b0;
			total_d     = 4'd0;
		end
	end

	// results of this byte: an optional entry or name result, then the status on eof
	always_comb begin
		cmhp_pkg::chunk_kind_t ck_mid;
		logic [2:0] hcnt_mid;
		res_a   = '0;
		res_b   = '0;
		res_a_v = 1'b0;
		if (in_hdr) begin
			hcnt_mid = hdr_done ? 3'd0 : hcnt_q + 3'd1;
			ck_mid   = (hdr_done && !size_zero) ? tag_kind : cmhp_pkg::CK_HEADER;
		end else begin
			hcnt_mid = hcnt_q;
			ck_mid   = body_end ? cmhp_pkg::CK_HEADER : ck_q;
		end
		if (grid_hit) begin
			res_a_v            = 1'b1;
			res_a.kind         = cmhp_pkg::KIND_TILE;
			res_a.tile_index   = ent_q[11:0];
			res_a.tile_present = byte_s1[0];
		end else if (name_hit) begin
			res_a_v          = 1'b1;
			res_a.kind       = cmhp_pkg::KIND_NAME;
			res_a.name_char  = byte_s1;
			res_a.name_first = (body_q == 32'd0);
		end else if (empty_body || empty_hdr) begin
			res_a_v          = 1'b1;
			res_a.kind       = cmhp_pkg::KIND_NAME;
			res_a.name_first = 1'b1;
		end
		res_a.last = !eof_s1;
		res_b.kind = cmhp_pkg::KIND_STATUS;
		res_b.last = 1'b1;
		res_b.header_flags      = flags_d;
		res_b.has_global_object = global_d;
		res_b.has_grid          = grid_d;
		if (commit_flags) begin
			res_b.header_flags      = pend_new;
			res_b.has_global_object = |(pend_new & cmhp_pkg::GLOBAL_MASK);
		end else begin
			res_b.header_flags      = flags_q;
			res_b.has_global_object = global_q;
		end
		res_b.has_grid = grid_q
			|| (body_end && (ck_q == cmhp_pkg::CK_MAIN))
			|| (hdr_done && size_zero && (tag_kind == cmhp_pkg::CK_MAIN));
		if (total_new < cmhp_pkg::MIN_FILE_BYTES)
			res_b.status = cmhp_pkg::ST_TOO_SHORT;
		else if (ck_mid != cmhp_pkg::CK_HEADER)
			res_b.status = cmhp_pkg::ST_TRUNC_BODY;
		else if (hcnt_mid != 3'd0)
			res_b.status = cmhp_pkg::ST_PARTIAL_HDR;
		else
			res_b.status = cmhp_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_q        <= cmhp_pkg::CK_HEADER;
			hcnt_q      <= 3'd0;
			tag_q       <= 32'd0;
			size_q      <= 32'd0;
			body_q      <= 32'd0;
			ph_q        <= '0;
			ent_q       <= 13'd0;
			name_open_q <= 1'b0;
			pend_q      <= 32'd0;
			flags_q     <= 32'd0;
			global_q    <= 1'b0;
			grid_q      <= 1'b0;
			total_q     <= 4'd0;
		end else if (fire) begin
			ck_q        <= ck_d;
			hcnt_q      <= hcnt_d;
			tag_q       <= tag_d;
			size_q      <= size_d;
			body_q      <= body_d;
			ph_q        <= ph_d;
			ent_q       <= ent_d;
			name_open_q <= name_open_d;
			pend_q      <= pend_d;
			flags_q     <= flags_d;
			global_q    <= global_d;
			grid_q      <= grid_d;
			total_q     <= total_d;
		end
	end

	// result queue, up to two pushes per byte
	logic [1:0] n_push;
	assign n_push = fire ? ({1'b0, res_a_v} + {1'b0, eof_s1}) : 2'd0;
	assign pop    = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (fire) begin
			if (res_a_v) begin
				q_mem_q[wr_ptr_q] <= res_a;
				if (eof_s1)
					q_mem_q[wr_ptr_q + QP_W'(1)] <= res_b;
			end else if (eof_s1) begin
				q_mem_q[wr_ptr_q] <= res_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QP_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			cnt_q <= cnt_q + (QP_W+1)'(n_push) - (QP_W+1)'(pop);
		end
	end

	cmhp_pkg::result_t head;
	assign head          = q_mem_q[rd_ptr_q];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {6'd0, head.status, head.has_grid, head.has_global_object,
		head.header_flags, head.name_first, head.name_char, head.tile_present,
		head.tile_index};

	`include "chunked_map_header_parser_assert.svh"

	`CMHP_ASSERT_NOW(a_room_on_fire, fire, cnt_q <= (QP_W+1)'(Q_DEPTH - 2), "queue overrun")
	`CMHP_ASSERT_NEXT(a_eof_clears, fire && eof_s1, (ck_q == cmhp_pkg::CK_HEADER) && (hcnt_q == 3'd0) && (total_q == 4'd0), "state not cleared after eof")
	`CMHP_ASSERT_NOW(a_name_in_mwmo, name_open_q, ck_q == cmhp_pkg::CK_MWMO, "name open outside name chunk")
	`CMHP_ASSERT_NOW(a_hcnt_in_hdr, hcnt_q != 3'd0, ck_q == cmhp_pkg::CK_HEADER, "header count in body")

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
import cmhp_pkg::*;

// scoreboard: parses the byte stream on its own and keeps the results still owed
class map_result_board;
	localparam int TILE_BYTES   = 8;
	localparam int GRID_ENTRIES = 64 * 64;

	// own copy of the parser state
	bit          tag_swap;
	bit [3:0]    hdr_count;
	bit [31:0]   tag_acc;
	bit [31:0]   chunk_len;
	bit [31:0]   body_pos;
	chunk_kind_t cur_chunk;
	bit [12:0]   entries;
	bit          name_live;
	bit [31:0]   flags_pend;
	bit [31:0]   flags_commit;
	bit          global_commit;
	bit          grid_done;
	bit [3:0]    byte_sat;

	result_t     step_q[$];
	result_t     expected_q[$];

	int          errors;
	int          n_tiles;
	int          n_names;
	int          n_status;
	int          status_seen[4];

	function new();
		tag_swap = 1'b0;
		clear_file();
	endfunction

	function void clear_file();
		hdr_count     = '0;
		tag_acc       = '0;
		chunk_len     = '0;
		body_pos      = '0;
		cur_chunk     = CK_HEADER;
		entries       = '0;
		name_live     = 1'b0;
		flags_pend    = '0;
		flags_commit  = '0;
		global_commit = 1'b0;
		grid_done     = 1'b0;
		byte_sat      = '0;
	endfunction

	function void set_tag_order(bit v);
		tag_swap = v;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function chunk_kind_t tag_kind(bit [31:0] t);
		bit [31:0] v;
		if (tag_swap)
			v = {<<8{t}};
		else
			v = t;
		case (v)
			TAG_MPHD: return CK_MPHD;
			TAG_MAIN: return CK_MAIN;
			TAG_MWMO: return CK_MWMO;
			default:  return CK_OTHER;
		endcase
	endfunction

	function result_t blank(res_kind_t k);
		result_t r;
		r      = '0;
		r.kind = k;
		return r;
	endfunction

	// name restarts as empty
	function void push_empty_name();
		result_t r;
		r            = blank(KIND_NAME);
		r.name_first = 1'b1;
		step_q.push_back(r);
	endfunction

	function void close_chunk();
		if (cur_chunk == CK_MPHD && chunk_len >= 4) begin
			flags_commit  = flags_pend;
			global_commit = (flags_pend & GLOBAL_MASK) != 0;
		end else if (cur_chunk == CK_MAIN) begin
			grid_done = 1'b1;
		end else if (cur_chunk == CK_MWMO && chunk_len == 0) begin
			push_empty_name();
		end
		cur_chunk = CK_HEADER;
		name_live = 1'b0;
	endfunction

	function void note_byte(bit [7:0] b, bit eof);
		result_t r;
		status_t st;
		if (byte_sat < 15)
			byte_sat++;
		if (cur_chunk == CK_HEADER) begin
			if (hdr_count == 0) begin
				tag_acc   = '0;
				chunk_len = '0;
			end
			if (hdr_count < 4)
				tag_acc = {tag_acc[23:0], b};
			else
				chunk_len = chunk_len | (32'(b) << (8 * (hdr_count - 4)));
			if (hdr_count == 7) begin
				hdr_count  = '0;
				cur_chunk  = tag_kind(tag_acc);
				body_pos   = '0;
				entries    = '0;
				flags_pend = '0;
				name_live  = (cur_chunk == CK_MWMO);
				if (chunk_len == 0)
					close_chunk();
			end else begin
				hdr_count++;
			end
		end else begin
			case (cur_chunk)
				CK_MPHD: begin
					if (body_pos < 4)
						flags_pend = flags_pend | (32'(b) << (8 * body_pos[1:0]));
				end
				CK_MAIN: begin
					if (body_pos % TILE_BYTES == 0 && entries < GRID_ENTRIES &&
						64'(body_pos) + TILE_BYTES <= 64'(chunk_len)) begin
						r              = blank(KIND_TILE);
						r.tile_index   = entries[11:0];
						r.tile_present = b[0];
						step_q.push_back(r);
						entries++;
					end
				end
				CK_MWMO: begin
					if (name_live) begin
						if (b != 0) begin
							r            = blank(KIND_NAME);
							r.name_char  = b;
							r.name_first = (body_pos == 0);
							step_q.push_back(r);
						end else begin
							if (body_pos == 0)
								push_empty_name();
							name_live = 1'b0;
						end
					end
				end
				default: ;
			endcase
			body_pos++;
			if (body_pos == chunk_len)
				close_chunk();
		end
		if (eof) begin
			if (byte_sat < MIN_FILE_BYTES)
				st = ST_TOO_SHORT;
			else if (cur_chunk != CK_HEADER)
				st = ST_TRUNC_BODY;
			else if (hdr_count != 0)
				st = ST_PARTIAL_HDR;
			else
				st = ST_OK;
			r                   = blank(KIND_STATUS);
			r.header_flags      = flags_commit;
			r.has_global_object = global_commit;
			r.has_grid          = grid_done;
			r.status            = st;
			step_q.push_back(r);
			clear_file();
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			expected_q.push_back(step_q[i]);
		step_q.delete();
	endfunction

	function void cmp(string field, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			errors++;
		end
	endfunction

	function void check_result(bit [63:0] d, bit [1:0] u, bit l);
		result_t e;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: kind %0d data %h", u, d);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		cmp("kind", e.kind, u);
		cmp("tile_index", e.tile_index, d[11:0]);
		cmp("tile_present", e.tile_present, d[12]);
		cmp("name_char", e.name_char, d[20:13]);
		cmp("name_first", e.name_first, d[21]);
		cmp("header_flags", e.header_flags, d[53:22]);
		cmp("has_global_object", e.has_global_object, d[54]);
		cmp("has_grid", e.has_grid, d[55]);
		cmp("status", e.status, d[57:56]);
		cmp("last_of_run", e.last, l);
		case (e.kind)
			KIND_TILE: n_tiles++;
			KIND_NAME: n_names++;
			default: begin
				n_status++;
				status_seen[e.status]++;
			end
		endcase
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] TAG_MODF        = 32'h4D4F_4446;
	localparam logic [31:0] TAG_POOL [4]    = '{TAG_MPHD, TAG_MAIN, TAG_MWMO, TAG_MODF};
	localparam int          WATCHDOG_CYCLES = 4000;
	localparam int          HOLD_CYCLES     = 160;
	localparam int          HOLD_AT_BYTE    = 200;
	localparam int          PHASE_BYTES     = 350;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	map_result_board sb;

	bit [7:0] file_q[$];      // bytes of the file being sent
	bit       cur_order;      // tag byte order the files are written in
	bit       steady;         // no idling on either side while set
	int       sent_bytes;
	int       bytes_in;       // byte requests taken by the parser

	chunked_map_header_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// file building: tag in the current byte order (or the other one when flipped)
	function automatic void put_tag(bit [31:0] t, bit flip);
		bit [31:0] w;
		if (cur_order ^ flip)
			w = {<<8{t}};
		else
			w = t;
		for (int i = 3; i >= 0; i--)
			file_q.push_back(w[8 * i +: 8]);
	endfunction

	// size field, little endian
	function automatic void put_size(bit [31:0] s);
		for (int i = 0; i < 4; i++)
			file_q.push_back(s[8 * i +: 8]);
	endfunction

	function automatic void put_random(int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// whole chunk; name bodies random nonzero bytes with an occasional nul
	function automatic void put_chunk(bit [31:0] tag, bit flip, bit [31:0] size);
		put_tag(tag, flip);
		put_size(size);
		for (int i = 0; i < size; i++) begin
			if (tag == TAG_MWMO)
				file_q.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
			else
				file_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// one byte request per file byte, tlast on the final one; random gaps
	// between requests unless steady
	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++) begin
			@(negedge clk);
			while (!steady && $urandom_range(0, 99) < 15) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= file_q[i];
			s_axis_tlast  <= (i == file_q.size() - 1);
			do @(posedge clk); while (!s_axis_tready);
		end
		sent_bytes += file_q.size();
	endtask

	task automatic write_cfg(bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, let every owed result come back, then keep waiting
	// since bytes with no result may still be in the pipe
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one setting of the tag order, then random files until the byte budget is spent
	task automatic run_phase(bit order, bit calm);
		int start;
		int pick;
		int sel;
		int ending;
		int cut;
		wait_idle();
		write_cfg(order);
		cur_order = order;
		steady    = calm;
		start = sent_bytes;
		while (sent_bytes - start < PHASE_BYTES) begin
			file_q.delete();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// junk file, mostly shorter than one chunk header
				put_random($urandom_range(1, 12));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					sel = $urandom_range(0, 99);
					if (sel < 20)
						put_chunk(TAG_MPHD, 1'b0, $urandom_range(0, 8));
					else if (sel < 45)
						put_chunk(TAG_MAIN, 1'b0, $urandom_range(0, 6) * 8 +
							(($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0));
					else if (sel < 68)
						put_chunk(TAG_MWMO, 1'b0, $urandom_range(0, 10));
					else if (sel < 80)
						put_chunk(TAG_MODF, 1'b0, $urandom_range(0, 6));
					else if (sel < 90)
						// known tag in the wrong byte order, must be skipped
						put_chunk(TAG_POOL[$urandom_range(0, 3)], 1'b1, $urandom_range(0, 4));
					else
						put_chunk($urandom(), 1'b0, $urandom_range(0, 4));
				end
				ending = $urandom_range(0, 99);
				if (ending < 75) begin
					// clean end on a chunk boundary
				end else if (ending < 85) begin
					// cut anywhere, usually inside a body
					cut = $urandom_range(1, file_q.size() - 1);
					while (file_q.size() > cut)
						void'(file_q.pop_back());
				end else if (ending < 92) begin
					// some bytes of a header that never completes
					put_random($urandom_range(1, 7));
				end else begin
					// huge size, body runs out
					put_tag(TAG_POOL[$urandom_range(0, 3)], 1'b0);
					put_size($urandom() | 32'h8000_0000);
					put_random($urandom_range(1, 24));
				end
			end
			send_file();
		end
	endtask

	// result side: random backpressure, plus one long hold-off once the input
	// has been running a while so the result queue fills and input stalls
	initial begin
		bit held;
		held          = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && bytes_in >= HOLD_AT_BYTE) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	// monitor: every accepted request goes to the scoreboard at the edge that takes it
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_byte(s_axis_tdata, s_axis_tlast);
				bytes_in++;
			end
			if (cfg_valid && cfg_ready)
				sb.set_tag_order(cfg_data[0]);
		end
	end

	// watchdog: too many cycles without any request moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cur_order     = 1'b0;
		steady        = 1'b0;
		sent_bytes    = 0;
		bytes_in      = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		write_cfg(1'b0);

		// directed: file shorter than a header, with extreme byte values
		file_q = '{8'h00, 8'hFF, 8'h80};
		send_file();
		// empty name chunk ending the file: empty name and status from one byte
		file_q.delete();
		put_chunk(TAG_MWMO, 1'b0, 0);
		send_file();
		// header chunk whose flags commit on the same byte as the file end
		file_q.delete();
		put_chunk(TAG_MPHD, 1'b0, 4);
		send_file();

		run_phase(1'b0, 1'b0);
		run_phase(1'b1, 1'b1);
		run_phase(1'b0, 1'b0);
		run_phase(1'b1, 1'b0);
		wait_idle();

		$display("tb: %0d bytes in %0d files: ok %0d, truncated %0d, partial header %0d, short %0d",
			sent_bytes, sb.n_status, sb.status_seen[ST_OK], sb.status_seen[ST_TRUNC_BODY],
			sb.status_seen[ST_PARTIAL_HDR], sb.status_seen[ST_TOO_SHORT]);
		$display("tb: %0d grid entries and %0d name bytes checked, both tag orders, one long stall",
			sb.n_tiles, sb.n_names);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
